// ===== hdl/b64e_pkg.sv =====
// Shared types, constants and the sextet-to-ASCII lookup for the base64 encoder.
// No dependencies; used by every module in hdl/.
package b64e_pkg;

  localparam int unsigned Q_DEPTH = 2;
  localparam logic [6:0]  PAD_CHAR = 7'd61;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_word_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last_char;
  } out_word_t;

  typedef struct packed {
    logic       pad;
    logic [5:0] six;
  } sym_t;

  typedef struct packed {
    sym_t [3:0] sym;
    logic [1:0] last_idx;
    logic       last;
  } job_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] count;
  } q_stat_t;

  function automatic logic [6:0] b64_char(input logic [5:0] six);
    logic [6:0] v;
    v = {1'b0, six};
    if (six < 6'd26) begin
      b64_char = v + 7'd65;
    end else if (six < 6'd52) begin
      b64_char = v + 7'd71;
    end else if (six < 6'd62) begin
      b64_char = v - 7'd4;
    end else if (six == 6'd62) begin
      b64_char = 7'd43;
    end else begin
      b64_char = 7'd47;
    end
  endfunction

endpackage

// ===== hdl/base64_stream_encoder_top.sv =====
// Top level of the streaming base64 encoder: front end, job queue, back end.
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
//
// One raw byte enters per input word; the encoder emits standard-alphabet
// characters, one per cycle while out_ready is high, with '=' padding after
// the final byte and last_char set on the closing character. A byte is taken
// in the same cycle it is offered while the two-entry job queue has room, so
// input words may arrive back to back. Each byte yields one character in the
// first group position, one in the second, two in the third, and up to four
// for a final byte; the single-character output register sends them out one
// at a time.
module base64_stream_encoder_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  b64e_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output b64e_pkg::out_word_t out_data
);

  b64e_pkg::job_t    wr_job, head;
  b64e_pkg::q_stat_t q_stat;
  logic              push, pop;

  b64e_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .job      (wr_job)
  );

  b64e_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .head   (head),
    .stat   (q_stat)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= 2'(b64e_pkg::Q_DEPTH))
    else $error("job queue over depth");

  a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == !q_stat.full)
    else $error("in_ready disagrees with queue room");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> q_stat.count == $past(q_stat.count) + 2'd1)
    else $error("queue count did not grow on push");

  a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule

// ===== hdl/b64e_front.sv =====
// Front end: accepts input words, tracks group phase and leftover bits,
// and builds one character job per byte. Depends on b64e_pkg.
module b64e_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  b64e_pkg::in_word_t in_data,
  input  b64e_pkg::q_stat_t  q_stat,
  output logic               push,
  output b64e_pkg::job_t     job
);

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] left_r, left_nxt;
  logic [7:0] b;
  logic       fin;

  assign b        = in_data.data_byte;
  assign fin      = in_data.end_of_data;
  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    job       = '0;
    job.last  = fin;
    phase_nxt = 2'd0;
    left_nxt  = 4'd0;
    case (phase_r)
      2'd1: begin
        job.sym[0].six = {left_r[1:0], b[7:4]};
        if (fin) begin
          job.sym[1].six = {b[3:0], 2'b00};
          job.sym[2].pad = 1'b1;
          job.last_idx   = 2'd2;
        end else begin
          phase_nxt = 2'd2;
          left_nxt  = b[3:0];
        end
      end
      2'd2: begin
        job.sym[0].six = {left_r, b[7:6]};
        job.sym[1].six = b[5:0];
        job.last_idx   = 2'd1;
      end
      default: begin
        job.sym[0].six = b[7:2];
        if (fin) begin
          job.sym[1].six = {b[1:0], 4'b0000};
          job.sym[2].pad = 1'b1;
          job.sym[3].pad = 1'b1;
          job.last_idx   = 2'd3;
        end else begin
          phase_nxt = 2'd1;
          left_nxt  = {2'b00, b[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      left_r  <= 4'd0;
    end else if (push) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

// ===== hdl/b64e_queue.sv =====
// Two-entry job queue between front and back end.
// Depends on b64e_pkg.
module b64e_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  b64e_pkg::job_t    wr_job,
  input  logic              pop,
  output b64e_pkg::job_t    head,
  output b64e_pkg::q_stat_t stat
);

  b64e_pkg::job_t mem_r [b64e_pkg::Q_DEPTH];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign stat.full  = (count_r == 2'(b64e_pkg::Q_DEPTH));
  assign stat.empty = (count_r == 2'd0);
  assign stat.count = count_r;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

// ===== hdl/b64e_back.sv =====
// Back end: walks the head job into the output register, one character per cycle
// while the output is not stalled. Depends on b64e_pkg.
module b64e_back (
  input  logic                clk,
  input  logic                rst_n,
  input  b64e_pkg::job_t      head,
  input  b64e_pkg::q_stat_t   q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output b64e_pkg::out_word_t out_data
);

  logic [1:0]          idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  b64e_pkg::out_word_t out_data_r, out_data_nxt;
  b64e_pkg::sym_t      cur;
  logic                load, at_end;

  assign cur       = head.sym[idx_r];
  assign at_end    = (idx_r == head.last_idx);
  assign load      = !q_stat.empty && (!out_valid_r || out_ready);
  assign pop       = load && at_end;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_data_nxt.out_char  = cur.pad ? b64e_pkg::PAD_CHAR : b64e_pkg::b64_char(cur.six);
    out_data_nxt.last_char = head.last && at_end;
    idx_nxt                = idx_r;
    out_valid_nxt          = out_valid_r && !out_ready;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = at_end ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for base64_stream_encoder_top: directed table, then random messages.
// Predicts output from table text or its encoder model; depends on b64e_pkg and the RTL in hdl/.
`timescale 1ns / 100ps

module tb_top;

  localparam int          TOTAL_WORDS = 470;
  localparam int          DIR_ROWS    = 23;
  localparam int          DRAIN_CYC   = 20;
  localparam int          MAX_REPORTS = 10;
  localparam int          EXP_DEPTH   = 4096;
  localparam longint      LIMIT_NS    = 64'd20_000_000;
  localparam logic [1:0]  PH_FIRST    = 2'd0;
  localparam logic [1:0]  PH_SECOND   = 2'd1;
  localparam logic [1:0]  PH_THIRD    = 2'd2;
  localparam logic [511:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        end_of_data;
    logic [2:0]  n_chars;
    logic [31:0] chars;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  b64e_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  b64e_pkg::out_word_t out_data;

  logic [2:0]          row_n = 3'd0;
  logic [31:0]         row_chars = 32'd0;
  logic                no_idle = 1'b0;
  int                  stall_left = 0;
  int                  bad_words = 0;
  logic [1:0]          grp_phase = PH_FIRST;
  logic [3:0]          left_bits = 4'd0;
  b64e_pkg::out_word_t exp_mem [EXP_DEPTH];
  int                  exp_wr = 0;
  int                  exp_rd = 0;

  always #10 clk = ~clk;

  base64_stream_encoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  function automatic dir_row_t dir_row(input int i);
    dir_row_t r;
    case (i)
      0:  r = '{8'h00, 1'b1, 3'd4, "AA=="};
      1:  r = '{8'hFF, 1'b1, 3'd4, "/w=="};
      2:  r = '{8'h00, 1'b0, 3'd1, "A"};
      3:  r = '{8'h00, 1'b1, 3'd3, "AA="};
      4:  r = '{8'hFF, 1'b0, 3'd1, "/"};
      5:  r = '{8'hFF, 1'b0, 3'd1, "/"};
      6:  r = '{8'hFF, 1'b1, 3'd2, "//"};
      7:  r = '{8'h4D, 1'b0, 3'd1, "T"};
      8:  r = '{8'h61, 1'b0, 3'd1, "W"};
      9:  r = '{8'h6E, 1'b1, 3'd2, "Fu"};
      10: r = '{8'h00, 1'b0, 3'd0, 32'd0};
      11: r = '{8'h00, 1'b0, 3'd0, 32'd0};
      12: r = '{8'h00, 1'b0, 3'd0, 32'd0};
      13: r = '{8'h55, 1'b0, 3'd0, 32'd0};
      14: r = '{8'hAA, 1'b0, 3'd0, 32'd0};
      15: r = '{8'h55, 1'b0, 3'd0, 32'd0};
      16: r = '{8'hAA, 1'b1, 3'd0, 32'd0};
      17: r = '{8'h80, 1'b0, 3'd0, 32'd0};
      18: r = '{8'h01, 1'b1, 3'd0, 32'd0};
      19: r = '{8'h7F, 1'b0, 3'd0, 32'd0};
      20: r = '{8'hFE, 1'b0, 3'd0, 32'd0};
      21: r = '{8'h3C, 1'b1, 3'd0, 32'd0};
      default: r = '{8'hF8, 1'b1, 3'd4, "+A=="};
    endcase
    return r;
  endfunction

  function automatic b64e_pkg::out_word_t sextet_word(input logic [5:0] six, input logic last);
    b64e_pkg::out_word_t w;
    w.out_char  = ALPHABET[8 * (63 - six) +: 7];
    w.last_char = last;
    return w;
  endfunction

  function automatic b64e_pkg::out_word_t pad_word(input logic last);
    b64e_pkg::out_word_t w;
    w.out_char  = b64e_pkg::PAD_CHAR;
    w.last_char = last;
    return w;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic put_exp(input b64e_pkg::out_word_t x);
    exp_mem[exp_wr[11:0]] = x;
    exp_wr++;
  endtask

  // advance the encoder state by one byte and queue the characters it yields
  task automatic encode_byte(input b64e_pkg::in_word_t w, input logic [2:0] n_typed,
                             input logic [31:0] typed);
    b64e_pkg::out_word_t pred [4];
    b64e_pkg::out_word_t t;
    int                  n_pred;
    n_pred = 0;
    case (grp_phase)
      PH_SECOND: begin
        pred[0] = sextet_word({left_bits[1:0], w.data_byte[7:4]}, 1'b0);
        n_pred  = 1;
        if (w.end_of_data) begin
          pred[1]   = sextet_word({w.data_byte[3:0], 2'b00}, 1'b0);
          pred[2]   = pad_word(1'b1);
          n_pred    = 3;
          grp_phase = PH_FIRST;
          left_bits = 4'd0;
        end else begin
          grp_phase = PH_THIRD;
          left_bits = w.data_byte[3:0];
        end
      end
      PH_THIRD: begin
        pred[0]   = sextet_word({left_bits, w.data_byte[7:6]}, 1'b0);
        pred[1]   = sextet_word(w.data_byte[5:0], w.end_of_data);
        n_pred    = 2;
        grp_phase = PH_FIRST;
        left_bits = 4'd0;
      end
      default: begin
        pred[0] = sextet_word(w.data_byte[7:2], 1'b0);
        n_pred  = 1;
        if (w.end_of_data) begin
          pred[1]   = sextet_word({w.data_byte[1:0], 4'd0}, 1'b0);
          pred[2]   = pad_word(1'b0);
          pred[3]   = pad_word(1'b1);
          n_pred    = 4;
          grp_phase = PH_FIRST;
          left_bits = 4'd0;
        end else begin
          grp_phase = PH_SECOND;
          left_bits = {2'b00, w.data_byte[1:0]};
        end
      end
    endcase
    if (n_typed == 3'd0) begin
      for (int k = 0; k < n_pred; k++) put_exp(pred[k]);
    end else begin
      for (int k = 0; k < n_typed; k++) begin
        t.out_char  = typed[8 * (n_typed - 1 - k) +: 7];
        t.last_char = w.end_of_data && (k == n_typed - 1);
        put_exp(t);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) encode_byte(in_data, row_n, row_chars);
      if (out_valid && out_ready) begin
        if (exp_wr == exp_rd) begin
          bad_words++;
          if (bad_words <= MAX_REPORTS)
            $display("unexpected word: char %0d last %0d", out_data.out_char,
                     out_data.last_char);
        end else begin
          b64e_pkg::out_word_t exp_w;
          exp_w = exp_mem[exp_rd[11:0]];
          exp_rd++;
          if (exp_w.out_char !== out_data.out_char ||
              exp_w.last_char !== out_data.last_char) begin
            bad_words++;
            if (bad_words <= MAX_REPORTS)
              $display("mismatch: char exp %0d got %0d, last exp %0d got %0d",
                       exp_w.out_char, out_data.out_char,
                       exp_w.last_char, out_data.last_char);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (no_idle) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      stall_left <= idle_len();
    end
  end

  task automatic push_word(input b64e_pkg::in_word_t w, input logic [2:0] n,
                           input logic [31:0] chars);
    int gap;
    gap = no_idle ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= w;
    row_n     <= n;
    row_chars <= chars;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold the input until every queued character has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (exp_wr != exp_rd) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    int                 n_sent;
    int                 len;
    dir_row_t           r;
    b64e_pkg::in_word_t w;
    n_sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < DIR_ROWS; i++) begin
      r = dir_row(i);
      w.data_byte   = r.data_byte;
      w.end_of_data = r.end_of_data;
      push_word(w, r.n_chars, r.chars);
      n_sent++;
    end
    drain();
    while (n_sent < TOTAL_WORDS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
      if (len > TOTAL_WORDS - n_sent) len = TOTAL_WORDS - n_sent;
      no_idle <= ($urandom_range(0, 5) == 0);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 7) == 0)
          w.data_byte = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else
          w.data_byte = 8'($urandom_range(0, 255));
        w.end_of_data = (k == len - 1);
        push_word(w, 3'd0, 32'd0);
        n_sent++;
      end
      if ($urandom_range(0, 19) == 0) drain();
    end
    drain();
    no_idle <= 1'b0;
    repeat (DRAIN_CYC) @(posedge clk);
    if (bad_words == 0 && exp_wr == exp_rd) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
